>>> design/tqc_pkg.sv
`timescale 1ns / 1ps

package tqc_pkg;

   localparam int COORD_WIDTH = 20;
   localparam int FRAC_BITS   = 16;

   // Internal coordinates carry headroom for sums of a few Q fields.
   localparam int IW  = COORD_WIDTH + 4;
   localparam int UW  = COORD_WIDTH - 1;
   localparam int NW  = IW - 1;
   localparam int PW  = COORD_WIDTH + NW;
   localparam int CNT_W = $clog2(COORD_WIDTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [IW-1:0] coord_type;

   localparam coord_type ONE_Q = coord_type'(longint'(1) << FRAC_BITS);
   localparam coord_type MAX_V = coord_type'((longint'(1) << (COORD_WIDTH - 1)) - 1);
   localparam coord_type MIN_V = coord_type'(-(longint'(1) << (COORD_WIDTH - 1)));

   localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
   localparam logic [2:0] REG_CLIP_WIDTH  = 3'd2;
   localparam logic [2:0] REG_CLIP_HEIGHT = 3'd3;
   localparam logic [2:0] REG_SHIFT_X     = 3'd4;
   localparam logic [2:0] REG_SHIFT_Y     = 3'd5;
   localparam logic [2:0] REG_COLOR       = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] clip_left;
      logic signed [COORD_WIDTH-1:0] clip_top;
      logic [UW-1:0]                 clip_width;
      logic [UW-1:0]                 clip_height;
      logic signed [COORD_WIDTH-1:0] shift_x;
      logic signed [COORD_WIDTH-1:0] shift_y;
      logic [31:0]                   color;
   } cfg_type;

   // One accepted rectangle after classification.
   typedef struct packed {
      coord_type  l;
      coord_type  t;
      coord_type  w;
      coord_type  h;
      coord_type  wl;
      coord_type  wt;
      coord_type  ww;
      coord_type  wh;
      coord_type  u0;
      coord_type  u1;
      coord_type  u2;
      coord_type  u3;
      coord_type  v0;
      coord_type  v1;
      coord_type  v2;
      coord_type  v3;
      logic [1:0] rot;
      logic       newtex;
   } rec_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input coord_type v);
      coord_type r;
      r = v;
      if (v > MAX_V) r = MAX_V;
      if (v < MIN_V) r = MIN_V;
      return r[COORD_WIDTH-1:0];
   endfunction

   // Corner emitted as vertex k of the two triangles.
   function automatic logic [1:0] corner_of(input logic [2:0] k);
      logic [1:0] c;
      case (k)
         3'd0: c = 2'd0;
         3'd1: c = 2'd1;
         3'd2: c = 2'd3;
         3'd3: c = 2'd0;
         3'd4: c = 2'd3;
         default: c = 2'd2;
      endcase
      return c;
   endfunction

endpackage

>>> design/textured_quad_clipper_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                      Payload
// req       push / full                    rect, texture window, rotation, texture id
// rsp       empty / pop                    one vertex: position, uv, color, flags
// csr       psel penable pwrite / pready   seven registers at byte address 4*i
//
// In the back end a rectangle is taken from the queue and its edges are checked
// one at a time; each clipped edge then goes through the shared multiply and the
// bit-serial divider, which yields one quotient bit per cycle, before six vertices
// are emitted.
// Culled rectangles are dropped at the front and produce no vertices.
// A two-entry queue between front and back lets new rectangles enter while
// vertices wait on a stalled result side. Reset is synchronous and active high.

module textured_quad_clipper_core import tqc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic signed [COORD_WIDTH-1:0] req_rect_left,
   input  logic signed [COORD_WIDTH-1:0] req_rect_top,
   input  logic [UW-1:0]                 req_rect_width,
   input  logic [UW-1:0]                 req_rect_height,
   input  logic signed [COORD_WIDTH-1:0] req_win_left,
   input  logic signed [COORD_WIDTH-1:0] req_win_top,
   input  logic signed [COORD_WIDTH-1:0] req_win_width,
   input  logic signed [COORD_WIDTH-1:0] req_win_height,
   input  logic [1:0]                    req_rotation,
   input  logic [31:0]                   req_texture_id,
   output logic                          empty,
   input  logic                          pop,
   output logic signed [COORD_WIDTH-1:0] rsp_vert_x,
   output logic signed [COORD_WIDTH-1:0] rsp_vert_y,
   output logic signed [COORD_WIDTH-1:0] rsp_tex_u,
   output logic signed [COORD_WIDTH-1:0] rsp_tex_v,
   output logic [31:0]                   rsp_out_color,
   output logic                          rsp_new_texture,
   output logic                          rsp_last_vertex,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [2:0] csr_index;
   logic       q_push, q_full, q_pop, q_empty;
   rec_type    push_rec, head_rec;

   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite;
      csr_index = paddr[4:2];
      cfg_in    = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CLIP_LEFT:   cfg_in.clip_left   = pwdata[COORD_WIDTH-1:0];
            REG_CLIP_TOP:    cfg_in.clip_top    = pwdata[COORD_WIDTH-1:0];
            REG_CLIP_WIDTH:  cfg_in.clip_width  = pwdata[UW-1:0];
            REG_CLIP_HEIGHT: cfg_in.clip_height = pwdata[UW-1:0];
            REG_SHIFT_X:     cfg_in.shift_x     = pwdata[COORD_WIDTH-1:0];
            REG_SHIFT_Y:     cfg_in.shift_y     = pwdata[COORD_WIDTH-1:0];
            REG_COLOR:       cfg_in.color       = pwdata;
            default: ;
         endcase
      end
      case (csr_index)
         REG_CLIP_LEFT:   prdata = 32'(cfg_ff.clip_left);
         REG_CLIP_TOP:    prdata = 32'(cfg_ff.clip_top);
         REG_CLIP_WIDTH:  prdata = 32'(cfg_ff.clip_width);
         REG_CLIP_HEIGHT: prdata = 32'(cfg_ff.clip_height);
         REG_SHIFT_X:     prdata = 32'(cfg_ff.shift_x);
         REG_SHIFT_Y:     prdata = 32'(cfg_ff.shift_y);
         REG_COLOR:       prdata = cfg_ff.color;
         default:         prdata = '0;
      endcase
      full = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left   <= '0;
         cfg_ff.clip_top    <= '0;
         cfg_ff.clip_width  <= UW'(longint'(1) << FRAC_BITS);
         cfg_ff.clip_height <= UW'(longint'(1) << FRAC_BITS);
         cfg_ff.shift_x     <= '0;
         cfg_ff.shift_y     <= '0;
         cfg_ff.color       <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tqc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (push),
      .q_full      (q_full),
      .rect_left   (req_rect_left),
      .rect_top    (req_rect_top),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .win_left    (req_win_left),
      .win_top     (req_win_top),
      .win_width   (req_win_width),
      .win_height  (req_win_height),
      .rotation    (req_rotation),
      .texture_id  (req_texture_id),
      .q_push      (q_push),
      .q_rec       (push_rec)
   );

   tqc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_rec (head_rec)
   );

   tqc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_rec       (head_rec),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .vert_x      (rsp_vert_x),
      .vert_y      (rsp_vert_y),
      .tex_u       (rsp_tex_u),
      .tex_v       (rsp_tex_v),
      .out_color   (rsp_out_color),
      .new_texture (rsp_new_texture),
      .last_vertex (rsp_last_vertex)
   );

endmodule

>>> design/tqc_front.sv
`timescale 1ns / 1ps

module tqc_front import tqc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          push,
   input  logic                          q_full,
   input  logic signed [COORD_WIDTH-1:0] rect_left,
   input  logic signed [COORD_WIDTH-1:0] rect_top,
   input  logic [UW-1:0]                 rect_width,
   input  logic [UW-1:0]                 rect_height,
   input  logic signed [COORD_WIDTH-1:0] win_left,
   input  logic signed [COORD_WIDTH-1:0] win_top,
   input  logic signed [COORD_WIDTH-1:0] win_width,
   input  logic signed [COORD_WIDTH-1:0] win_height,
   input  logic [1:0]                    rotation,
   input  logic [31:0]                   texture_id,
   output logic                          q_push,
   output rec_type                       q_rec
);

   logic [31:0] last_texture_ff;
   logic [31:0] last_texture_in;
   coord_type   l, t, w, h, wl, wt, ww, wh, wr, wb;
   coord_type   cl, ct, cr, cb;
   logic        culled;
   logic        accept;

   always_comb begin
      l  = coord_type'(rect_left);
      t  = coord_type'(rect_top);
      w  = coord_type'(rect_width);
      h  = coord_type'(rect_height);
      wl = coord_type'(win_left);
      wt = coord_type'(win_top);
      ww = coord_type'(win_width);
      wh = coord_type'(win_height);
      wr = wl + ww;
      wb = wt + wh;
      cl = coord_type'(cfg.clip_left);
      ct = coord_type'(cfg.clip_top);
      cr = cl + coord_type'(cfg.clip_width);
      cb = ct + coord_type'(cfg.clip_height);
      culled = (l + w < cl) || (t + h < ct) || (l > cr) || (t > cb);
      accept = push && !q_full;
      q_push = accept && !culled;

      q_rec.l = l;
      q_rec.t = t;
      q_rec.w = w;
      q_rec.h = h;
      q_rec.wl = wl;
      q_rec.wt = wt;
      q_rec.ww = ww;
      q_rec.wh = wh;
      q_rec.rot = rotation;
      q_rec.newtex = (texture_id != last_texture_ff);
      case (rotation)
         2'd0: begin
            q_rec.u0 = wl; q_rec.v0 = wt; q_rec.u1 = wr; q_rec.v1 = wt;
            q_rec.u2 = wl; q_rec.v2 = wb; q_rec.u3 = wr; q_rec.v3 = wb;
         end
         2'd1: begin
            q_rec.u0 = wl; q_rec.v0 = wb; q_rec.u1 = wl; q_rec.v1 = wt;
            q_rec.u2 = wr; q_rec.v2 = wb; q_rec.u3 = wr; q_rec.v3 = wt;
         end
         2'd2: begin
            q_rec.u0 = wr; q_rec.v0 = wb; q_rec.u1 = wl; q_rec.v1 = wb;
            q_rec.u2 = wr; q_rec.v2 = wt; q_rec.u3 = wl; q_rec.v3 = wt;
         end
         default: begin
            q_rec.u0 = wr; q_rec.v0 = wt; q_rec.u1 = wr; q_rec.v1 = wb;
            q_rec.u2 = wl; q_rec.v2 = wt; q_rec.u3 = wl; q_rec.v3 = wb;
         end
      endcase

      last_texture_in = last_texture_ff;
      if (q_push) last_texture_in = texture_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_texture_ff <= '1;
      end else begin
         last_texture_ff <= last_texture_in;
      end
   end

endmodule

>>> design/tqc_queue.sv
`timescale 1ns / 1ps

module tqc_queue import tqc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rec_type head_rec
);

   rec_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
      empty    = (count_ff == '0);
      head_rec = mem_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      // The depth is a power of two, so the pointers wrap on their own.
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_rec;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/tqc_back.sv
`timescale 1ns / 1ps

module tqc_back import tqc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          q_empty,
   input  rec_type                       q_rec,
   output logic                          q_pop,
   output logic                          empty,
   input  logic                          pop,
   output logic signed [COORD_WIDTH-1:0] vert_x,
   output logic signed [COORD_WIDTH-1:0] vert_y,
   output logic signed [COORD_WIDTH-1:0] tex_u,
   output logic signed [COORD_WIDTH-1:0] tex_v,
   output logic [31:0]                   out_color,
   output logic                          new_texture,
   output logic                          last_vertex
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_MUL, ST_LOAD, ST_DIV, ST_APPLY, ST_EMIT
   } state_type;

   typedef struct packed {
      state_type                     state;
      logic [1:0]                    step;
      logic [2:0]                    k;
      rec_type                       r;
      logic [NW-1:0]                 num;
      logic [NW-1:0]                 den;
      logic                          den_zero;
      logic [COORD_WIDTH-1:0]        mag;
      logic                          neg;
      coord_type                     lo;
      coord_type                     span;
      logic                          axis_u;
      logic                          up;
      logic [1:0]                    pi;
      logic [1:0]                    pj;
      logic [PW-1:0]                 prod;
      logic [NW:0]                   rem;
      logic [COORD_WIDTH-1:0]        dq;
      logic [CNT_W-1:0]              cnt;
      logic                          out_valid;
      logic signed [COORD_WIDTH-1:0] o_x;
      logic signed [COORD_WIDTH-1:0] o_y;
      logic signed [COORD_WIDTH-1:0] o_u;
      logic signed [COORD_WIDTH-1:0] o_v;
      logic [31:0]                   o_color;
      logic                          o_newtex;
      logic                          o_last;
   } ctx_type;

   ctx_type   ctx_ff, ctx_in;
   coord_type cl, ct, cr, cb;
   coord_type num_raw, den_raw, numc, f, val;
   coord_type x1, x2, y1, y2, cu, cv;
   logic      cond, horiz;
   logic [1:0] ci, cj, corner;
   logic [NW:0] rem_s;

   always_comb begin
      ctx_in = ctx_ff;
      q_pop  = 1'b0;
      cl = coord_type'(cfg.clip_left);
      ct = coord_type'(cfg.clip_top);
      cr = cl + coord_type'(cfg.clip_width);
      cb = ct + coord_type'(cfg.clip_height);
      cond = 1'b0;
      horiz = 1'b1;
      ci = 2'd0;
      cj = 2'd2;
      num_raw = '0;
      den_raw = '0;
      numc = '0;
      f = '0;
      val = '0;
      rem_s = '0;
      x1 = ctx_ff.r.l + coord_type'(cfg.shift_x);
      x2 = ctx_ff.r.l + ctx_ff.r.w + coord_type'(cfg.shift_x);
      y1 = ONE_Q - ctx_ff.r.t - coord_type'(cfg.shift_y);
      y2 = ONE_Q - (ctx_ff.r.t + ctx_ff.r.h) - coord_type'(cfg.shift_y);
      corner = corner_of(ctx_ff.k);
      case (corner)
         2'd0: begin cu = ctx_ff.r.u0; cv = ctx_ff.r.v0; end
         2'd1: begin cu = ctx_ff.r.u1; cv = ctx_ff.r.v1; end
         2'd2: begin cu = ctx_ff.r.u2; cv = ctx_ff.r.v2; end
         default: begin cu = ctx_ff.r.u3; cv = ctx_ff.r.v3; end
      endcase

      if (pop && ctx_ff.out_valid) ctx_in.out_valid = 1'b0;

      case (ctx_ff.state)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               ctx_in.r = q_rec;
               ctx_in.step = 2'd0;
               ctx_in.state = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (ctx_ff.step)
               2'd0: begin
                  cond = ctx_ff.r.l < cl;
                  num_raw = cl - ctx_ff.r.l;
                  den_raw = ctx_ff.r.w;
                  horiz = 1'b1; ci = 2'd0; cj = 2'd2;
                  if (cond) begin
                     ctx_in.r.w = ctx_ff.r.w - num_raw;
                     ctx_in.r.l = cl;
                  end
               end
               2'd1: begin
                  cond = ctx_ff.r.t < ct;
                  num_raw = ct - ctx_ff.r.t;
                  den_raw = ctx_ff.r.h;
                  horiz = 1'b0; ci = 2'd0; cj = 2'd1;
                  if (cond) begin
                     ctx_in.r.h = ctx_ff.r.h - num_raw;
                     ctx_in.r.t = ct;
                  end
               end
               2'd2: begin
                  cond = ctx_ff.r.l + ctx_ff.r.w > cr;
                  num_raw = cr - ctx_ff.r.l;
                  den_raw = ctx_ff.r.w;
                  horiz = 1'b1; ci = 2'd1; cj = 2'd3;
                  if (cond) ctx_in.r.w = num_raw;
               end
               default: begin
                  cond = ctx_ff.r.t + ctx_ff.r.h > cb;
                  num_raw = cb - ctx_ff.r.t;
                  den_raw = ctx_ff.r.h;
                  horiz = 1'b0; ci = 2'd2; cj = 2'd3;
                  if (cond) ctx_in.r.h = num_raw;
               end
            endcase
            numc = num_raw;
            if (num_raw < 0) numc = '0;
            if (num_raw > den_raw) numc = den_raw;
            if (cond) begin
               ctx_in.num = numc[NW-1:0];
               ctx_in.den = den_raw[NW-1:0];
               ctx_in.den_zero = (den_raw <= 0);
               ctx_in.pi = ci;
               ctx_in.pj = cj;
               if (horiz) begin
                  ctx_in.axis_u = !ctx_ff.r.rot[0];
                  ctx_in.up = (ctx_ff.r.rot == 2'd0) || (ctx_ff.r.rot == 2'd3);
               end else begin
                  ctx_in.axis_u = ctx_ff.r.rot[0];
                  ctx_in.up = !ctx_ff.r.rot[1];
               end
               if (horiz == !ctx_ff.r.rot[0]) begin
                  ctx_in.lo = ctx_ff.r.wl;
                  ctx_in.span = ctx_ff.r.ww;
                  ctx_in.neg = ctx_ff.r.ww < 0;
                  ctx_in.mag = ctx_ff.r.ww < 0 ? COORD_WIDTH'(-ctx_ff.r.ww)
                                               : COORD_WIDTH'(ctx_ff.r.ww);
               end else begin
                  ctx_in.lo = ctx_ff.r.wt;
                  ctx_in.span = ctx_ff.r.wh;
                  ctx_in.neg = ctx_ff.r.wh < 0;
                  ctx_in.mag = ctx_ff.r.wh < 0 ? COORD_WIDTH'(-ctx_ff.r.wh)
                                               : COORD_WIDTH'(ctx_ff.r.wh);
               end
               ctx_in.state = ST_MUL;
            end else if (ctx_ff.step == 2'd3) begin
               ctx_in.k = '0;
               ctx_in.state = ST_EMIT;
            end else begin
               ctx_in.step = ctx_ff.step + 1'b1;
            end
         end
         ST_MUL: begin
            ctx_in.prod = PW'(ctx_ff.mag) * PW'(ctx_ff.num);
            ctx_in.state = ST_LOAD;
         end
         ST_LOAD: begin
            // The quotient never exceeds the span magnitude, so the upper
            // part of the product is already below the divisor.
            ctx_in.rem = {1'b0, ctx_ff.prod[PW-1:COORD_WIDTH]};
            ctx_in.dq = ctx_ff.prod[COORD_WIDTH-1:0];
            ctx_in.cnt = '0;
            ctx_in.state = ST_DIV;
         end
         ST_DIV: begin
            rem_s = {ctx_ff.rem[NW-1:0], ctx_ff.dq[COORD_WIDTH-1]};
            if (rem_s >= {1'b0, ctx_ff.den}) begin
               ctx_in.rem = rem_s - {1'b0, ctx_ff.den};
               ctx_in.dq = {ctx_ff.dq[COORD_WIDTH-2:0], 1'b1};
            end else begin
               ctx_in.rem = rem_s;
               ctx_in.dq = {ctx_ff.dq[COORD_WIDTH-2:0], 1'b0};
            end
            ctx_in.cnt = ctx_ff.cnt + 1'b1;
            if (ctx_ff.cnt == CNT_W'(COORD_WIDTH - 1)) ctx_in.state = ST_APPLY;
         end
         ST_APPLY: begin
            f = ctx_ff.den_zero ? '0 : coord_type'(ctx_ff.dq);
            if (ctx_ff.neg) f = -f;
            val = ctx_ff.up ? ctx_ff.lo + f : ctx_ff.lo + ctx_ff.span - f;
            if (ctx_ff.axis_u) begin
               if (ctx_ff.pi == 2'd0 || ctx_ff.pj == 2'd0) ctx_in.r.u0 = val;
               if (ctx_ff.pi == 2'd1 || ctx_ff.pj == 2'd1) ctx_in.r.u1 = val;
               if (ctx_ff.pi == 2'd2 || ctx_ff.pj == 2'd2) ctx_in.r.u2 = val;
               if (ctx_ff.pi == 2'd3 || ctx_ff.pj == 2'd3) ctx_in.r.u3 = val;
            end else begin
               if (ctx_ff.pi == 2'd0 || ctx_ff.pj == 2'd0) ctx_in.r.v0 = val;
               if (ctx_ff.pi == 2'd1 || ctx_ff.pj == 2'd1) ctx_in.r.v1 = val;
               if (ctx_ff.pi == 2'd2 || ctx_ff.pj == 2'd2) ctx_in.r.v2 = val;
               if (ctx_ff.pi == 2'd3 || ctx_ff.pj == 2'd3) ctx_in.r.v3 = val;
            end
            if (ctx_ff.step == 2'd3) begin
               ctx_in.k = '0;
               ctx_in.state = ST_EMIT;
            end else begin
               ctx_in.step = ctx_ff.step + 1'b1;
               ctx_in.state = ST_CHECK;
            end
         end
         ST_EMIT: begin
            if (!ctx_ff.out_valid || pop) begin
               ctx_in.out_valid = 1'b1;
               ctx_in.o_x = sat_coord(corner[0] ? x2 : x1);
               ctx_in.o_y = sat_coord(corner[1] ? y2 : y1);
               ctx_in.o_u = sat_coord(cu);
               ctx_in.o_v = sat_coord(cv);
               ctx_in.o_color = cfg.color;
               ctx_in.o_newtex = (ctx_ff.k == 3'd0) && ctx_ff.r.newtex;
               ctx_in.o_last = (ctx_ff.k == 3'd5);
               ctx_in.k = ctx_ff.k + 1'b1;
               if (ctx_ff.k == 3'd5) ctx_in.state = ST_IDLE;
            end
         end
         default: ctx_in.state = ST_IDLE;
      endcase

      empty       = !ctx_ff.out_valid;
      vert_x      = ctx_ff.o_x;
      vert_y      = ctx_ff.o_y;
      tex_u       = ctx_ff.o_u;
      tex_v       = ctx_ff.o_v;
      out_color   = ctx_ff.o_color;
      new_texture = ctx_ff.o_newtex;
      last_vertex = ctx_ff.o_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state     <= ST_IDLE;
         ctx_ff.out_valid <= 1'b0;
         ctx_ff.step      <= '0;
         ctx_ff.k         <= '0;
      end else begin
         ctx_ff <= ctx_in;
      end
   end

endmodule

>>> test/textured_quad_clipper_core_tb.sv
`timescale 1ns / 1ps

module textured_quad_clipper_core_tb;
   import tqc_pkg::*;

   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam longint CMAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint CMIN = -(longint'(1) << (COORD_WIDTH - 1));
   localparam longint UMAX = (longint'(1) << UW) - 1;
   localparam int IDLE_LIMIT = 4000;
   localparam int STALL_CYCLES = 400;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] rect_left;
      logic signed [COORD_WIDTH-1:0] rect_top;
      logic [UW-1:0]                 rect_width;
      logic [UW-1:0]                 rect_height;
      logic signed [COORD_WIDTH-1:0] win_left;
      logic signed [COORD_WIDTH-1:0] win_top;
      logic signed [COORD_WIDTH-1:0] win_width;
      logic signed [COORD_WIDTH-1:0] win_height;
      logic [1:0]                    rotation;
      logic [31:0]                   texture_id;
   } rect_item_type;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] u;
      logic signed [COORD_WIDTH-1:0] v;
      logic [31:0]                   color;
      logic                          new_tex;
      logic                          last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [COORD_WIDTH-1:0] req_rect_left = '0;
   logic signed [COORD_WIDTH-1:0] req_rect_top = '0;
   logic [UW-1:0]                 req_rect_width = '0;
   logic [UW-1:0]                 req_rect_height = '0;
   logic signed [COORD_WIDTH-1:0] req_win_left = '0;
   logic signed [COORD_WIDTH-1:0] req_win_top = '0;
   logic signed [COORD_WIDTH-1:0] req_win_width = '0;
   logic signed [COORD_WIDTH-1:0] req_win_height = '0;
   logic [1:0]                    req_rotation = '0;
   logic [31:0]                   req_texture_id = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [COORD_WIDTH-1:0] rsp_vert_x;
   logic signed [COORD_WIDTH-1:0] rsp_vert_y;
   logic signed [COORD_WIDTH-1:0] rsp_tex_u;
   logic signed [COORD_WIDTH-1:0] rsp_tex_v;
   logic [31:0]                   rsp_out_color;
   logic                          rsp_new_texture;
   logic                          rsp_last_vertex;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   textured_quad_clipper_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the configuration and texture state.
   longint cfg_cl = 0, cfg_ct = 0, cfg_cw = ONE, cfg_ch = ONE, cfg_sx = 0, cfg_sy = 0;
   logic [31:0] cfg_color = 32'hFFFF_FFFF;
   logic [31:0] last_tex = 32'hFFFF_FFFF;

   rect_item_type pending_rects[$];
   vertex_type    quad_verts[$];
   rect_item_type cur_rect;
   int errors = 0, rects_sent = 0, rects_culled = 0, verts_seen = 0;
   int send_gap = 0, recv_gap = 0, idle_cycles = 0;
   int rsp_wait = 0;
   int stall_left = 0;
   bit stall_req = 1'b0;
   bit stall_done = 1'b0;
   bit req_taken, rsp_taken;
   vertex_type want;

   // Window and corner coordinates of the rectangle being predicted.
   longint win_l, win_t, win_w, win_h;
   longint cu[4], cv[4];

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord20(longint val);
      if (val > CMAX) val = CMAX;
      if (val < CMIN) val = CMIN;
      return val[COORD_WIDTH-1:0];
   endfunction

   // Re-interpolates one coordinate of corners i and j after an edge clip.
   function automatic void clip_corner_pair(logic [1:0] rot, bit horiz, int i, int j,
                                            longint num, longint den);
      bit axis_u, up;
      longint lo, span, mag, q, val;
      if (horiz) begin
         axis_u = (rot == 0 || rot == 2);
         up = (rot == 0 || rot == 3);
      end else begin
         axis_u = (rot == 1 || rot == 3);
         up = (rot <= 1);
      end
      lo = axis_u ? win_l : win_t;
      span = axis_u ? win_w : win_h;
      q = 0;
      if (den > 0) begin
         if (num < 0) num = 0;
         if (num > den) num = den;
         mag = (span < 0) ? -span : span;
         q = (mag * num) / den;
         if (span < 0) q = -q;
      end
      val = up ? lo + q : lo + span - q;
      if (axis_u) begin
         cu[i] = val;
         cu[j] = val;
      end else begin
         cv[i] = val;
         cv[j] = val;
      end
   endfunction

   function automatic void add_rect(rect_item_type it);
      pending_rects = {pending_rects, it};
   endfunction

   function automatic void predict_quad(rect_item_type it);
      longint l, t, w, h, wr, wb, nw, nh, x1, x2, y1, y2;
      int order[6] = '{0, 1, 3, 0, 3, 2};
      int c;
      vertex_type vx;
      logic new_tex;
      l = it.rect_left;
      t = it.rect_top;
      w = it.rect_width;
      h = it.rect_height;
      win_l = it.win_left;
      win_t = it.win_top;
      win_w = it.win_width;
      win_h = it.win_height;
      wr = win_l + win_w;
      wb = win_t + win_h;
      if (l + w < cfg_cl || t + h < cfg_ct || l > cfg_cl + cfg_cw || t > cfg_ct + cfg_ch) begin
         rects_culled++;
         return;
      end
      new_tex = (it.texture_id != last_tex);
      last_tex = it.texture_id;
      case (it.rotation)
         2'd0: begin
            cu = '{win_l, wr, win_l, wr};
            cv = '{win_t, win_t, wb, wb};
         end
         2'd1: begin
            cu = '{win_l, win_l, wr, wr};
            cv = '{wb, win_t, wb, win_t};
         end
         2'd2: begin
            cu = '{wr, win_l, wr, win_l};
            cv = '{wb, wb, win_t, win_t};
         end
         default: begin
            cu = '{wr, wr, win_l, win_l};
            cv = '{win_t, wb, win_t, wb};
         end
      endcase
      if (l < cfg_cl) begin
         clip_corner_pair(it.rotation, 1'b1, 0, 2, cfg_cl - l, w);
         w -= cfg_cl - l;
         l = cfg_cl;
      end
      if (t < cfg_ct) begin
         clip_corner_pair(it.rotation, 1'b0, 0, 1, cfg_ct - t, h);
         h -= cfg_ct - t;
         t = cfg_ct;
      end
      if (l + w > cfg_cl + cfg_cw) begin
         nw = cfg_cl + cfg_cw - l;
         clip_corner_pair(it.rotation, 1'b1, 1, 3, nw, w);
         w = nw;
      end
      if (t + h > cfg_ct + cfg_ch) begin
         nh = cfg_ct + cfg_ch - t;
         clip_corner_pair(it.rotation, 1'b0, 2, 3, nh, h);
         h = nh;
      end
      x1 = l + cfg_sx;
      x2 = l + w + cfg_sx;
      y1 = ONE - t - cfg_sy;
      y2 = ONE - (t + h) - cfg_sy;
      for (int k = 0; k < 6; k++) begin
         c = order[k];
         vx.x = sat_coord20(c[0] ? x2 : x1);
         vx.y = sat_coord20(c[1] ? y2 : y1);
         vx.u = sat_coord20(cu[c]);
         vx.v = sat_coord20(cv[c]);
         vx.color = cfg_color;
         vx.new_tex = (k == 0) ? new_tex : 1'b0;
         vx.last = (k == 5);
         quad_verts = {quad_verts, vx};
      end
   endfunction

   function automatic rect_item_type make_rect(longint l, t, w, h, wl, wt, ww, wh,
                                               int rot, logic [31:0] tex);
      rect_item_type it;
      it.rect_left = l[COORD_WIDTH-1:0];
      it.rect_top = t[COORD_WIDTH-1:0];
      it.rect_width = w[UW-1:0];
      it.rect_height = h[UW-1:0];
      it.win_left = wl[COORD_WIDTH-1:0];
      it.win_top = wt[COORD_WIDTH-1:0];
      it.win_width = ww[COORD_WIDTH-1:0];
      it.win_height = wh[COORD_WIDTH-1:0];
      it.rotation = rot[1:0];
      it.texture_id = tex;
      return it;
   endfunction

   function automatic longint pick(longint lo, longint hi);
      if (hi <= lo) return lo;
      return lo + longint'($urandom_range(0, int'(hi - lo)));
   endfunction

   // Mostly rectangles near the clip window with random content; some raw noise.
   function automatic rect_item_type random_rect();
      rect_item_type it;
      longint sw, sh, l, t, w, h;
      logic [31:0] tex;
      int tex_pick;
      tex_pick = $urandom_range(0, 3);
      tex = (tex_pick == 0) ? 32'hFFFF_FFFF : (tex_pick == 1) ? 32'd7 :
            (tex_pick == 2) ? 32'd8 : $urandom;
      if ($urandom_range(0, 9) == 0) begin
         it = make_rect($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom_range(0, 3), $urandom);
         return it;
      end
      sw = (cfg_cw > 0) ? cfg_cw : 16;
      sh = (cfg_ch > 0) ? cfg_ch : 16;
      l = cfg_cl + pick(-sw / 2 - 8, sw + 8);
      t = cfg_ct + pick(-sh / 2 - 8, sh + 8);
      w = pick(0, (sw + sw / 2 > UMAX) ? UMAX : sw + sw / 2);
      h = pick(0, (sh + sh / 2 > UMAX) ? UMAX : sh + sh / 2);
      if ($urandom_range(0, 1))
         it = make_rect(l, t, w, h, pick(-ONE, ONE), pick(-ONE, ONE), pick(-2 * ONE, 2 * ONE),
                        pick(-2 * ONE, 2 * ONE), $urandom_range(0, 3), tex);
      else
         it = make_rect(l, t, w, h, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 3), tex);
      return it;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
      $display("mismatch on vertex %0d, %s: got %h expected %h", verts_seen, field, got, exp);
      errors++;
   endtask

   // Driver: one transaction at a time from the pending queue.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         req_taken = push && !full;
         if (req_taken) begin
            predict_quad(cur_rect);
            rects_sent++;
         end
         if (!push || req_taken) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               push <= 1'b0;
            end else if (pending_rects.size() != 0) begin
               cur_rect = pending_rects.pop_front();
               req_rect_left <= cur_rect.rect_left;
               req_rect_top <= cur_rect.rect_top;
               req_rect_width <= cur_rect.rect_width;
               req_rect_height <= cur_rect.rect_height;
               req_win_left <= cur_rect.win_left;
               req_win_top <= cur_rect.win_top;
               req_win_width <= cur_rect.win_width;
               req_win_height <= cur_rect.win_height;
               req_rotation <= cur_rect.rotation;
               req_texture_id <= cur_rect.texture_id;
               push <= 1'b1;
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every popped vertex against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         rsp_taken = pop && !empty;
         if (rsp_taken) begin
            verts_seen++;
            if (quad_verts.size() == 0) begin
               report_mismatch("vertex count", verts_seen, verts_seen - 1);
            end else begin
               want = quad_verts.pop_front();
               if (rsp_vert_x !== want.x) report_mismatch("vert_x", rsp_vert_x, want.x);
               if (rsp_vert_y !== want.y) report_mismatch("vert_y", rsp_vert_y, want.y);
               if (rsp_tex_u !== want.u) report_mismatch("tex_u", rsp_tex_u, want.u);
               if (rsp_tex_v !== want.v) report_mismatch("tex_v", rsp_tex_v, want.v);
               if (rsp_out_color !== want.color)
                  report_mismatch("out_color", rsp_out_color, want.color);
               if (rsp_new_texture !== want.new_tex)
                  report_mismatch("new_texture", rsp_new_texture, want.new_tex);
               if (rsp_last_vertex !== want.last)
                  report_mismatch("last_vertex", rsp_last_vertex, want.last);
            end
         end
         if (stall_req && !stall_done) begin
            // Hold off the result side for a long stretch, counted here.
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            pop <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
         end else if (rsp_taken) begin
            rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (rsp_wait == 0) begin
               pop <= 1'b1;
            end else begin
               recv_gap <= rsp_wait - 1;
               pop <= 1'b0;
            end
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, longint value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value[31:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_CLIP_LEFT:   cfg_cl = longint'($signed(value[COORD_WIDTH-1:0]));
         REG_CLIP_TOP:    cfg_ct = longint'($signed(value[COORD_WIDTH-1:0]));
         REG_CLIP_WIDTH:  cfg_cw = value & UMAX;
         REG_CLIP_HEIGHT: cfg_ch = value & UMAX;
         REG_SHIFT_X:     cfg_sx = longint'($signed(value[COORD_WIDTH-1:0]));
         REG_SHIFT_Y:     cfg_sy = longint'($signed(value[COORD_WIDTH-1:0]));
         default:         cfg_color = value[31:0];
      endcase
   endtask

   task automatic drain();
      while (pending_rects.size() != 0 || push) @(posedge clock);
      while (quad_verts.size() != 0) @(posedge clock);
      // Culled rectangles leave no result to wait for, so allow the full latency.
      repeat (120) @(posedge clock);
   endtask

   task automatic set_clip(longint cl, ct, cw, ch, sx, sy, logic [31:0] color);
      csr_write(REG_CLIP_LEFT, cl);
      csr_write(REG_CLIP_TOP, ct);
      csr_write(REG_CLIP_WIDTH, cw);
      csr_write(REG_CLIP_HEIGHT, ch);
      csr_write(REG_SHIFT_X, sx);
      csr_write(REG_SHIFT_Y, sy);
      csr_write(REG_COLOR, color);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed set under the reset clip window of 0..1.0 on both axes.
      add_rect(make_rect(ONE / 4, ONE / 4, ONE / 2, ONE / 2,
                         0, 0, ONE, ONE, 0, 32'hFFFF_FFFF));
      for (int r = 0; r < 4; r++) begin
         add_rect(make_rect(ONE / 8, ONE / 8, ONE / 2, ONE / 4,
                            ONE / 4, 0, ONE, -ONE / 2, r, r));
         add_rect(make_rect(-ONE / 2, -ONE / 2, 2 * ONE, 2 * ONE,
                            0, 0, ONE, ONE, r, 32'd5));
      end
      // One rectangle culled past each edge.
      add_rect(make_rect(-2 * ONE, 0, ONE, ONE, 0, 0, ONE, ONE, 0, 32'd9));
      add_rect(make_rect(0, -2 * ONE, ONE, ONE, 0, 0, ONE, ONE, 0, 32'd9));
      add_rect(make_rect(ONE + 1, 0, ONE, ONE, 0, 0, ONE, ONE, 0, 32'd9));
      add_rect(make_rect(0, ONE + 1, ONE, ONE, 0, 0, ONE, ONE, 0, 32'd9));
      // Touching edges is kept.
      add_rect(make_rect(-ONE, -ONE, ONE, ONE, 0, 0, ONE, ONE, 1, 32'd9));
      add_rect(make_rect(ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, 2, 32'd0));
      // Field extremes.
      add_rect(make_rect(CMIN, CMIN, UMAX, UMAX, CMIN, CMAX, CMAX, CMIN,
                         3, 32'hFFFF_FFFF));
      add_rect(make_rect(CMAX, CMAX, UMAX, UMAX, CMAX, CMIN, CMIN, CMAX,
                         0, 32'h0));
      add_rect(make_rect(ONE / 2, ONE / 2, 0, 0, CMAX, CMAX, CMAX, CMAX,
                         1, 32'h0));
      add_rect(make_rect(-ONE / 2, ONE / 2, ONE / 4, 0, 0, 0, ONE, ONE,
                         2, 32'h1));
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_clip(-2 * ONE, -ONE, 4 * ONE, 3 * ONE, ONE / 2, -ONE / 4, 32'h1234_5678);
            1: set_clip(CMIN, CMIN, UMAX, UMAX, CMAX, CMIN, 32'h0);
            2: set_clip(CMAX, CMAX, 0, 0, CMIN, CMAX, 32'hFFFF_FFFF);
            default: set_clip(pick(CMIN, CMAX), pick(CMIN, CMAX), pick(0, UMAX),
                              pick(0, UMAX), pick(CMIN, CMAX), pick(CMIN, CMAX), $urandom);
         endcase
         // In one phase the result side holds off while the sender keeps offering.
         if (phase == 1) stall_req = 1'b1;
         for (int n = 0; n < 50; n++) add_rect(random_rect());
         drain();
      end

      $display("sent %0d rectangles (%0d culled), checked %0d vertices",
               rects_sent, rects_culled, verts_seen);
      $display("covered six clip settings including extremes, all rotations and a long stall");
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
design/tqc_pkg.sv
design/tqc_front.sv
design/tqc_queue.sv
design/tqc_back.sv
design/textured_quad_clipper_core.sv
test/textured_quad_clipper_core_tb.sv
